FILE: hdl/arp_and_udp_echo_responder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ARP / UDP echo responder
// ----------------------------------------------------------------------------
`ifndef ARP_AND_UDP_ECHO_RESPONDER_CORE_MACROS_SVH
`define ARP_AND_UDP_ECHO_RESPONDER_CORE_MACROS_SVH

// same-cycle implication
`define ARU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ARU check failed");

// next-cycle implication
`define ARU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ARU check failed");

`endif

FILE: hdl/aru_pkg.sv
// ----------------------------------------------------------------------------
// aru_pkg
// Shared constants and types for the ARP / UDP echo responder.
// ----------------------------------------------------------------------------
package aru_pkg;

   localparam int HDR_LEN    = 42;
   localparam int UDP_DECIDE = 37;
   localparam int ARP_DECIDE = 41;
   localparam int POS_W      = 6;

   localparam logic [1:0] CSR_OWN_MAC   = 2'd0;
   localparam logic [1:0] CSR_OWN_IP    = 2'd1;
   localparam logic [1:0] CSR_ECHO_PORT = 2'd2;

   localparam logic [15:0] ETH_ARP  = 16'h0806;
   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_UDP   = 8'd17;
   localparam logic [15:0] ARP_REQ  = 16'h0001;
   localparam logic [15:0] ARP_REP  = 16'h0002;

   // element j is wire byte j of the header
   typedef logic [HDR_LEN-1:0][7:0] hdr_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

FILE: hdl/aru_cell.sv
// ----------------------------------------------------------------------------
// aru_cell
// One byte cell of the header chain: hold, take neighbour's byte, or load.
// ----------------------------------------------------------------------------
module aru_cell (
   input  logic                  clock,
   input  aru_pkg::cell_ctl_type ctl,
   input  logic [7:0]            load_val,
   input  logic [7:0]            next_val,
   output logic [7:0]            value_o
);

   logic [7:0] val_ff;
   logic [7:0] val_in;

   always_comb begin
      val_in = val_ff;
      if (ctl.load) begin
         val_in = load_val;
      end else if (ctl.shift) begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign value_o = val_ff;

endmodule

FILE: hdl/aru_chain.sv
// ----------------------------------------------------------------------------
// aru_chain
// Row of header cells. Bytes enter at the top cell and move towards cell 0.
// ----------------------------------------------------------------------------
module aru_chain (
   input  logic                  clock,
   input  aru_pkg::cell_ctl_type ctl,
   input  logic [7:0]            shift_in,
   input  aru_pkg::hdr_type      load_vals,
   output aru_pkg::hdr_type      cells_o
);

   for (genvar i = 0; i < aru_pkg::HDR_LEN; i++) begin : g_cell
      logic [7:0] nxt;
      if (i == aru_pkg::HDR_LEN - 1) begin : g_top
         assign nxt = shift_in;
      end else begin : g_mid
         assign nxt = cells_o[i+1];
      end
      aru_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .load_val (load_vals[i]),
         .next_val (nxt),
         .value_o  (cells_o[i])
      );
   end

endmodule

FILE: hdl/arp_and_udp_echo_responder_core.sv
// ----------------------------------------------------------------------------
// arp_and_udp_echo_responder_core
// Answers ARP requests for own_ip and mirrors UDP datagrams to echo_port.
// ----------------------------------------------------------------------------
// Path: a matching frame's rewritten header loads into the header chain at its
// decision byte (byte 37 for UDP, 41 for ARP), then leaves via the output
// register; pass bytes go straight to it. Throughput: one byte per cycle when
// not back-pressured; input stalls while 38 (UDP) or 42 (ARP) bytes drain.
// Reset: synchronous; clears control and CSRs; header cells, rsp data not reset.
module arp_and_udp_echo_responder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // out_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   typedef enum logic [3:0] {
      ST_WAIT  = 4'b0001,
      ST_DRAIN = 4'b0010,
      ST_PASS  = 4'b0100,
      ST_DROP  = 4'b1000
   } state_type;

   localparam logic [aru_pkg::POS_W-1:0] UDP_POS = aru_pkg::POS_W'(aru_pkg::UDP_DECIDE);
   localparam logic [aru_pkg::POS_W-1:0] ARP_POS = aru_pkg::POS_W'(aru_pkg::ARP_DECIDE);
   localparam logic [aru_pkg::POS_W-1:0] UDP_CNT = aru_pkg::POS_W'(aru_pkg::UDP_DECIDE + 1);
   localparam logic [aru_pkg::POS_W-1:0] ARP_CNT = aru_pkg::POS_W'(aru_pkg::ARP_DECIDE + 1);

   state_type                   state_ff, state_in;
   logic [aru_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [aru_pkg::POS_W-1:0]   cnt_ff, cnt_in;
   logic                        end_pend_ff, end_pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic [47:0]                 own_mac_ff;
   logic [31:0]                 own_ip_ff;
   logic [15:0]                 echo_port_ff;

   aru_pkg::hdr_type      cells;
   aru_pkg::hdr_type      hu, ha, ru, ra, load_vals;
   aru_pkg::cell_ctl_type ctl;

   logic out_free;
   logic req_beat;
   logic wait_beat;
   logic pass_beat;
   logic drain_step;
   logic udp_hit;
   logic arp_hit;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;
   assign wait_beat  = req_beat && (state_ff == ST_WAIT);
   assign pass_beat  = req_beat && (state_ff == ST_PASS);
   assign drain_step = (state_ff == ST_DRAIN) && out_free;

   always_comb begin
      case (state_ff)
         ST_WAIT:  req_tready = !reset;
         ST_DROP:  req_tready = !reset;
         ST_PASS:  req_tready = out_free;
         ST_DRAIN: req_tready = 1'b0;
         default:  req_tready = 1'b0;
      endcase
   end

   // header views with the current byte appended, byte 0 in element 0
   always_comb begin
      hu        = '0;
      hu[37:0]  = {req_tdata, cells[41:5]};
      ha        = {req_tdata, cells[41:1]};
   end

   assign udp_hit = (pos_ff == UDP_POS) && ({hu[12], hu[13]} == aru_pkg::ETH_IPV4) &&
                    (hu[23] == aru_pkg::IP_UDP) && ({hu[36], hu[37]} == echo_port_ff);
   assign arp_hit = (pos_ff == ARP_POS) && ({ha[12], ha[13]} == aru_pkg::ETH_ARP) &&
                    ({ha[20], ha[21]} == aru_pkg::ARP_REQ) &&
                    ({ha[38], ha[39], ha[40], ha[41]} == own_ip_ff);

   // UDP: swap MACs, IPs and ports
   always_comb begin
      ru = hu;
      for (int i = 0; i < 6; i++) begin
         ru[i]   = hu[6+i];
         ru[6+i] = hu[i];
      end
      for (int i = 0; i < 4; i++) begin
         ru[26+i] = hu[30+i];
         ru[30+i] = hu[26+i];
      end
      for (int i = 0; i < 2; i++) begin
         ru[34+i] = hu[36+i];
         ru[36+i] = hu[34+i];
      end
   end

   // ARP: request into reply
   always_comb begin
      ra = ha;
      for (int i = 0; i < 6; i++) begin
         ra[i]    = ha[6+i];
         ra[6+i]  = own_mac_ff[8*(5-i) +: 8];
         ra[32+i] = ha[22+i];
         ra[22+i] = own_mac_ff[8*(5-i) +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         ra[38+i] = ha[28+i];
         ra[28+i] = own_ip_ff[8*(3-i) +: 8];
      end
      ra[20] = aru_pkg::ARP_REP[15:8];
      ra[21] = aru_pkg::ARP_REP[7:0];
   end

   assign load_vals = udp_hit ? ru : ra;
   assign ctl.load  = wait_beat && (udp_hit || arp_hit);
   assign ctl.shift = (wait_beat && !(udp_hit || arp_hit)) || drain_step;

   aru_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .shift_in  (req_tdata),
      .load_vals (load_vals),
      .cells_o   (cells)
   );

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      end_pend_in  = end_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_WAIT: begin
            if (wait_beat) begin
               pos_in = pos_ff + 1'b1;
               if (udp_hit || arp_hit) begin
                  state_in    = ST_DRAIN;
                  pos_in      = '0;
                  cnt_in      = udp_hit ? UDP_CNT : ARP_CNT;
                  end_pend_in = req_tlast;
               end else if (req_tlast) begin
                  pos_in = '0;
               end else if (pos_ff == ARP_POS) begin
                  state_in = ST_DROP;
                  pos_in   = '0;
               end
            end
         end
         ST_DRAIN: begin
            if (drain_step) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = cells[0];
               rsp_last_in  = end_pend_ff && (cnt_ff == 1);
               cnt_in       = cnt_ff - 1'b1;
               if (cnt_ff == 1) begin
                  state_in = end_pend_ff ? ST_WAIT : ST_PASS;
               end
            end
         end
         ST_PASS: begin
            if (pass_beat) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = req_tdata;
               rsp_last_in  = req_tlast;
               if (req_tlast) begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_DROP: begin
            if (req_beat && req_tlast) begin
               state_in = ST_WAIT;
            end
         end
         default: begin
            state_in = ST_WAIT;
            pos_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         end_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         own_mac_ff   <= '0;
         own_ip_ff    <= '0;
         echo_port_ff <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         end_pend_ff  <= end_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               aru_pkg::CSR_OWN_MAC:   own_mac_ff   <= csr_data;
               aru_pkg::CSR_OWN_IP:    own_ip_ff    <= csr_data[31:0];
               aru_pkg::CSR_ECHO_PORT: echo_port_ff <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/aru_checker.sv
// ----------------------------------------------------------------------------
// aru_checker
// Port-level checks on the responder, bound to the top level.
// ----------------------------------------------------------------------------
`include "arp_and_udp_echo_responder_core_macros.svh"

module aru_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       csr_ready
);

   // a stalled result beat stays put
   `ARU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ARU_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast))
   // output register empties on reset
   `ARU_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid)
   // register writes are not back-pressured outside reset
   `ARU_ASSERT_SAME(a_csr_ready, clock, reset, 1'b1, csr_ready)

endmodule

bind arp_and_udp_echo_responder_core aru_checker u_aru_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);
